>>> sv/tcit_pkg.sv
// Shared types and constants for the three channel interval timer.
package tcit_pkg;

   localparam int NUM_COUNTERS = 3;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [1:0] CTRL_PORT = 2'd3;

   localparam logic [1:0] FMT_LATCH = 2'd0;
   localparam logic [1:0] FMT_LO    = 2'd1;
   localparam logic [1:0] FMT_HI    = 2'd2;

   localparam logic [15:0] COUNT_RESET = 16'hffff;

   // Byte access sequencing per counter
   typedef enum logic [2:0] {
      PH_LAT_LO  = 3'd0,
      PH_LAT_HI  = 3'd1,
      PH_HI_ONLY = 3'd2,
      PH_LO_ONLY = 3'd3,
      PH_LOHI_LO = 3'd4,
      PH_LOHI_HI = 3'd5
   } tcit_phase_type;

   typedef struct packed {
      logic       tick;
      logic       rd;
      logic       wr;
      logic       ctrl;
      logic [7:0] data;
   } tcit_cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
   } tcit_stat_type;

endpackage

>>> sv/tcit_if.sv
// Request and response channel interfaces of the interval timer.
interface tcit_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [1:0] port;
   logic [7:0] write_data;

   modport source (output valid, output operation, output port, output write_data,
                   input ready);
   modport sink   (input valid, input operation, input port, input write_data,
                   output ready);
endinterface

interface tcit_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq;

   modport source (output valid, output read_data, output irq, input ready);
   modport sink   (input valid, input read_data, input irq, output ready);
endinterface

>>> sv/three_channel_interval_timer_unit.sv
// Top level of the three channel interval timer: request register, counters, response register.
//
//   channel   direction  payload                          handshake
//   req_chan  in         operation, port, write_data      valid/ready
//   rsp_chan  out        read_data, irq                   valid/ready
//
// Each request waits in the request register until it can move on; the counters update and
// the response register loads at the same edge, and the response register then holds the
// result until it is taken. One request per cycle is sustained while responses are taken;
// with both registers full, request ready follows response ready.
// Reset (synchronous) sets every count, reload and latch to 0xffff.
// A stalled response holds the request register; requests stop only then.
module three_channel_interval_timer_unit (
   input  logic       clock,
   input  logic       reset,
   tcit_req_if.sink   req_chan,
   tcit_rsp_if.source rsp_chan
);

   logic       s1_valid_ff;
   logic [1:0] s1_op_ff;
   logic [1:0] s1_port_ff;
   logic [7:0] s1_data_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_rdata_ff, rsp_rdata_in;
   logic       rsp_irq_ff, rsp_irq_in;

   logic s1_fire;

   tcit_pkg::tcit_cmd_type  cmd  [tcit_pkg::NUM_COUNTERS];
   tcit_pkg::tcit_stat_type stat [tcit_pkg::NUM_COUNTERS];

   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_rdata_ff;
   assign rsp_chan.irq       = rsp_irq_ff;

   for (genvar i = 0; i < tcit_pkg::NUM_COUNTERS; i++) begin : g_cnt
      always_comb begin
         cmd[i].tick = s1_fire && (s1_op_ff == tcit_pkg::OP_TICK);
         cmd[i].rd   = s1_fire && (s1_op_ff == tcit_pkg::OP_READ) && (s1_port_ff == 2'(i));
         cmd[i].wr   = s1_fire && (s1_op_ff == tcit_pkg::OP_WRITE) && (s1_port_ff == 2'(i));
         cmd[i].ctrl = s1_fire && (s1_op_ff == tcit_pkg::OP_WRITE)
                       && (s1_port_ff == tcit_pkg::CTRL_PORT) && (s1_data_ff[7:6] == 2'(i));
         cmd[i].data = s1_data_ff;
      end

      tcit_counter u_counter (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[i]),
         .stat  (stat[i])
      );
   end

   // only the addressed counter drives a nonzero byte
   always_comb begin
      rsp_rdata_in = '0;
      rsp_irq_in   = 1'b0;
      for (int i = 0; i < tcit_pkg::NUM_COUNTERS; i++) begin
         rsp_rdata_in = rsp_rdata_in | stat[i].read_data;
         rsp_irq_in   = rsp_irq_in | stat[i].irq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         s1_op_ff   <= req_chan.operation;
         s1_port_ff <= req_chan.port;
         s1_data_ff <= req_chan.write_data;
      end
      if (s1_fire) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_irq_ff   <= rsp_irq_in;
      end
   end

endmodule

>>> sv/tcit_counter.sv
// One 16-bit down counter with its reload, latch and byte access state.
module tcit_counter (
   input  logic                   clock,
   input  logic                   reset,
   input  tcit_pkg::tcit_cmd_type cmd,
   output tcit_pkg::tcit_stat_type stat
);

   logic [15:0]              reload_ff, reload_in;
   logic [15:0]              count_ff, count_in;
   logic [15:0]              latch_ff, latch_in;
   tcit_pkg::tcit_phase_type phase_ff, phase_in;
   logic [2:0]               mode_ff, mode_in;
   logic                     bcd_ff, bcd_in;

   always_comb begin
      reload_in = reload_ff;
      count_in  = count_ff;
      latch_in  = latch_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      bcd_in    = bcd_ff;
      stat.read_data = '0;
      stat.irq       = 1'b0;

      if (cmd.tick) begin
         if (count_ff == '0) begin
            count_in = reload_ff;
            stat.irq = (mode_ff == 3'd0);
         end else begin
            count_in = count_ff - 16'd1;
         end
      end

      if (cmd.rd) begin
         case (phase_ff)
            tcit_pkg::PH_LAT_LO: begin
               stat.read_data = latch_ff[7:0];
               phase_in = tcit_pkg::PH_LAT_HI;
            end
            tcit_pkg::PH_LAT_HI: begin
               stat.read_data = latch_ff[15:8];
               phase_in = tcit_pkg::PH_LAT_LO;
            end
            tcit_pkg::PH_HI_ONLY: stat.read_data = count_ff[15:8];
            tcit_pkg::PH_LO_ONLY: stat.read_data = count_ff[7:0];
            tcit_pkg::PH_LOHI_LO: begin
               stat.read_data = count_ff[7:0];
               phase_in = tcit_pkg::PH_LOHI_HI;
            end
            tcit_pkg::PH_LOHI_HI: begin
               stat.read_data = count_ff[15:8];
               phase_in = tcit_pkg::PH_LOHI_LO;
            end
            default: ;
         endcase
      end

      if (cmd.wr) begin
         case (phase_ff)
            tcit_pkg::PH_HI_ONLY: begin
               reload_in = {cmd.data, reload_ff[7:0]};
               count_in  = {cmd.data, reload_ff[7:0]};
            end
            tcit_pkg::PH_LO_ONLY: begin
               reload_in = {reload_ff[15:8], cmd.data};
               count_in  = {reload_ff[15:8], cmd.data};
            end
            tcit_pkg::PH_LOHI_LO: begin
               // first byte of a pair: hold the count
               reload_in = {reload_ff[15:8], cmd.data};
               phase_in  = tcit_pkg::PH_LOHI_HI;
            end
            tcit_pkg::PH_LOHI_HI: begin
               reload_in = {cmd.data, reload_ff[7:0]};
               count_in  = {cmd.data, reload_ff[7:0]};
               phase_in  = tcit_pkg::PH_LOHI_LO;
            end
            default: ;
         endcase
      end

      if (cmd.ctrl) begin
         bcd_in   = cmd.data[0];
         mode_in  = cmd.data[3:1];
         count_in = reload_ff;
         case (cmd.data[5:4])
            tcit_pkg::FMT_LATCH: begin
               phase_in = tcit_pkg::PH_LAT_LO;
               latch_in = count_ff;
            end
            tcit_pkg::FMT_LO: phase_in = tcit_pkg::PH_LO_ONLY;
            tcit_pkg::FMT_HI: phase_in = tcit_pkg::PH_HI_ONLY;
            default:          phase_in = tcit_pkg::PH_LOHI_LO;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= tcit_pkg::COUNT_RESET;
         count_ff  <= tcit_pkg::COUNT_RESET;
         latch_ff  <= tcit_pkg::COUNT_RESET;
         phase_ff  <= tcit_pkg::PH_LAT_LO;
         mode_ff   <= '0;
         bcd_ff    <= 1'b0;
      end else begin
         reload_ff <= reload_in;
         count_ff  <= count_in;
         latch_ff  <= latch_in;
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         bcd_ff    <= bcd_in;
      end
   end

endmodule
